// ===== rtl/tt_pkg.sv =====
// types, constants and codes shared by the transposition table modules
`timescale 1ns / 1ps
`default_nettype none

package tt_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int KEY_W = 64;
    localparam int MOD_W = 13;
    localparam int STEP_BITS = 8;
    localparam int STEPS = KEY_W / STEP_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_UPPER = 2'd1;
    localparam logic [1:0] BOUND_LOWER = 2'd2;

    localparam logic CFG_ENTRIES_IN_USE = 1'b0;
    localparam logic CFG_UNKNOWN_VALUE  = 1'b1;

    localparam logic [MOD_W-1:0] ENTRIES_RESET = 13'd4096;
    localparam logic [15:0]      UNKNOWN_RESET = 16'h8000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [KEY_W-1:0]  position_key;
        logic [7:0]        search_depth;
        logic signed [15:0] score;
        logic [1:0]        bound_type;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } tt_req_t;

    typedef struct packed {
        logic              hit;
        logic signed [15:0] value;
    } tt_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
    } tt_entry_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [IDX_W-1:0] addr;
        tt_entry_t        wdata;
    } tt_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/tt_mod_unit.sv =====
// iterative remainder of the 64-bit key by the entry count, eight bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module tt_mod_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [tt_pkg::KEY_W-1:0]  key,
    input  wire logic [tt_pkg::MOD_W-1:0]  modulus,
    output logic                           done,
    output logic [tt_pkg::MOD_W-1:0]       remainder
);
    import tt_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0]      shift_reg, shift_next;
    logic [MOD_W-1:0]      rem_reg, rem_next;
    logic [MOD_W-1:0]      mod_reg, mod_next;
    logic [MOD_W-1:0]      rem_step;

    always_comb
    begin
        logic [MOD_W:0] r;
        r = '0;
        rem_step = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            r = {rem_step, shift_reg[KEY_W-1-i]};
            if (r >= {1'b0, mod_reg})
            begin
                r = r - {1'b0, mod_reg};
            end
            rem_step = r[MOD_W-1:0];
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        mod_next   = mod_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = key;
            rem_next   = '0;
            mod_next   = modulus;
        end
        else if (busy_reg)
        begin
            rem_next   = rem_step;
            shift_next = shift_reg << STEP_BITS;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        mod_reg   <= mod_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/tt_store.sv =====
// entry memory, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module tt_store (
    input  wire logic                clk,
    input  wire tt_pkg::tt_mem_req_t mem_req,
    output tt_pkg::tt_entry_t        rdata
);
    import tt_pkg::*;

    tt_entry_t mem_reg [TABLE_ENTRIES];
    tt_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem_reg[mem_req.addr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem_reg[mem_req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/transposition_table.sv =====
// top level of the transposition table: control, configuration and result register
//
// usage
//   req channel (req_valid/req_ready/req) carries one item: insert, lookup or
//   clear; kind three is taken and dropped. rsp channel (rsp_valid/rsp_ready/rsp)
//   carries one item for each lookup only.
//   cfg_we/cfg_index/cfg_data write entries_in_use (0) or unknown_value (1).
//   one item is worked on at a time. insert and lookup first take the key
//   modulo the entry count, eight bits a cycle, then the memory is written or
//   read. an insert returns to idle with the write; a lookup reads the entry,
//   compares it and registers the result, raising rsp_valid.
//   clear sweeps the memory one entry a cycle, all 4096 entries.
//   after reset the same sweep runs and req_ready stays low;
//   configuration writes are taken during it.
//   the result sits in an output register; the next item is accepted while
//   it waits. a lookup that finishes while the receiver still stalls holds
//   until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module transposition_table (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire tt_pkg::tt_req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output tt_pkg::tt_rsp_t      rsp,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [15:0]     cfg_data
);
    import tt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    tt_req_t          item_reg, item_next;
    logic             rsp_valid_reg, rsp_valid_next;
    tt_rsp_t          rsp_reg, rsp_next;
    logic [MOD_W-1:0] entries_reg;
    logic [15:0]      unknown_reg;

    logic             accept;
    logic             div_start;
    logic             div_done;
    logic [MOD_W-1:0] div_rem;
    logic [MOD_W-1:0] modulus;
    tt_mem_req_t      mem_req;
    tt_entry_t        rdata;
    tt_rsp_t          lookup_rsp;

    always_comb
    begin
        if (entries_reg == '0)
        begin
            modulus = MOD_W'(1);
        end
        else if (32'(entries_reg) > TABLE_ENTRIES)
        begin
            modulus = MOD_W'(TABLE_ENTRIES);
        end
        else
        begin
            modulus = entries_reg;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign div_start = accept && (req.kind == KIND_INSERT || req.kind == KIND_LOOKUP);

    tt_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .key       (req.position_key),
        .modulus   (modulus),
        .done      (div_done),
        .remainder (div_rem)
    );

    tt_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    always_comb
    begin
        lookup_rsp.hit   = 1'b0;
        lookup_rsp.value = $signed(unknown_reg);
        if (rdata.key == item_reg.position_key && rdata.depth >= item_reg.search_depth)
        begin
            case (rdata.bound)
                BOUND_EXACT:
                begin
                    lookup_rsp.hit   = 1'b1;
                    lookup_rsp.value = rdata.score;
                end
                BOUND_UPPER:
                begin
                    if ($signed(rdata.score) <= $signed(item_reg.alpha))
                    begin
                        lookup_rsp.hit   = 1'b1;
                        lookup_rsp.value = item_reg.alpha;
                    end
                end
                BOUND_LOWER:
                begin
                    if ($signed(rdata.score) >= $signed(item_reg.beta))
                    begin
                        lookup_rsp.hit   = 1'b1;
                        lookup_rsp.value = item_reg.beta;
                    end
                end
                default:
                begin
                    lookup_rsp.hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        mem_req.we          = 1'b0;
        mem_req.re          = 1'b0;
        mem_req.addr        = IDX_W'(div_rem);
        mem_req.wdata.key   = item_reg.position_key;
        mem_req.wdata.depth = item_reg.search_depth;
        mem_req.wdata.score = item_reg.score;
        mem_req.wdata.bound = item_reg.bound_type;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = req;
                    if (req.kind == KIND_INSERT || req.kind == KIND_LOOKUP)
                    begin
                        state_next = S_DIV;
                    end
                    else if (req.kind == KIND_CLEAR)
                    begin
                        clr_cnt_next = '0;
                        state_next   = S_CLEAR;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (item_reg.kind == KIND_INSERT)
                    begin
                        mem_req.we = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_req.re = 1'b1;
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = lookup_rsp;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_cnt_reg;
                mem_req.wdata = '0;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            entries_reg   <= ENTRIES_RESET;
            unknown_reg   <= UNKNOWN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we && cfg_index == CFG_ENTRIES_IN_USE)
            begin
                entries_reg <= cfg_data[MOD_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_UNKNOWN_VALUE)
            begin
                unknown_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/tt_checker.sv =====
// port-level assertions for the transposition table and their bind
`timescale 1ns / 1ps
`default_nettype none

module tt_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_ready,
    input wire tt_pkg::tt_req_t req,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire tt_pkg::tt_rsp_t rsp
);
    import tt_pkg::*;

    // the clearing sweep holds off items during and right after reset
    a_reset_busy: assert property (@(posedge clk) !rst_n |=> !req_ready)
        else $error("req_ready high during reset");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.kind == KIND_CLEAR) |=> !req_ready)
        else $error("item taken right after a clear");

    a_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.kind == KIND_INSERT || req.kind == KIND_LOOKUP))
        |=> (!req_ready && !$rose(rsp_valid)))
        else $error("insert or lookup finished too early");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result item changed");

endmodule

bind transposition_table tt_checker u_tt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ===== tb/transposition_table_tb.sv =====
`timescale 1ns / 1ps
// testbench for transposition_table: directed and random items checked against a behavioral table
module transposition_table_tb;
    import tt_pkg::*;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam logic [1:0] BOUND_UNUSED = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 118;
    localparam int POOL_DEPTH = 32;
    localparam int SETTLE_CYCLES = 4200;
    localparam int DRAIN_CYCLES = 50;
    localparam int WATCHDOG_LIMIT = 30000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    tt_req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    tt_rsp_t rsp;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    tt_req_t pending_items[$];
    tt_rsp_t lookup_answers[$];
    tt_req_t inserted_pool[$];

    logic [63:0] tab_key[TABLE_ENTRIES];
    logic [7:0] tab_depth[TABLE_ENTRIES];
    logic signed [15:0] tab_score[TABLE_ENTRIES];
    logic [1:0] tab_bound[TABLE_ENTRIES];
    logic [MOD_W-1:0] entries_cfg = ENTRIES_RESET;
    logic [15:0] unknown_cfg = UNKNOWN_RESET;

    int idle_mode = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    transposition_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_table();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tab_key[i] = '0;
            tab_depth[i] = '0;
            tab_score[i] = '0;
            tab_bound[i] = BOUND_EXACT;
        end
    endfunction

    function automatic int slot_of(logic [63:0] key);
        logic [63:0] n;
        n = 64'(entries_cfg);
        if (n == 0)
            n = 1;
        if (n > TABLE_ENTRIES)
            n = TABLE_ENTRIES;
        return int'(key % n);
    endfunction

    function automatic void predict_table_op(tt_req_t item);
        int s;
        logic signed [15:0] a;
        logic signed [15:0] b;
        tt_rsp_t ans;
        a = item.alpha;
        b = item.beta;
        case (item.kind)
            KIND_CLEAR: clear_table();
            KIND_INSERT:
            begin
                s = slot_of(item.position_key);
                tab_key[s] = item.position_key;
                tab_depth[s] = item.search_depth;
                tab_score[s] = item.score;
                tab_bound[s] = item.bound_type;
            end
            KIND_LOOKUP:
            begin
                s = slot_of(item.position_key);
                ans.hit = 1'b0;
                ans.value = unknown_cfg;
                if (tab_key[s] == item.position_key && tab_depth[s] >= item.search_depth)
                begin
                    case (tab_bound[s])
                        BOUND_EXACT:
                        begin
                            ans.hit = 1'b1;
                            ans.value = tab_score[s];
                        end
                        BOUND_UPPER:
                            if (tab_score[s] <= a)
                            begin
                                ans.hit = 1'b1;
                                ans.value = a;
                            end
                        BOUND_LOWER:
                            if (tab_score[s] >= b)
                            begin
                                ans.hit = 1'b1;
                                ans.value = b;
                            end
                        default: ;
                    endcase
                end
                lookup_answers.push_back(ans);
            end
            default: ;
        endcase
    endfunction

    function automatic tt_req_t make_item(logic [1:0] kind, logic [63:0] key, logic [7:0] depth,
                                          logic [15:0] score, logic [1:0] bound,
                                          logic [15:0] alpha, logic [15:0] beta);
        tt_req_t it;
        it.kind = kind;
        it.position_key = key;
        it.search_depth = depth;
        it.score = score;
        it.bound_type = bound;
        it.alpha = alpha;
        it.beta = beta;
        return it;
    endfunction

    function automatic logic [15:0] random_score();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] near_score(logic signed [15:0] v);
        int t;
        t = int'(v) + int'($urandom_range(6)) - 3;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return 16'(t);
    endfunction

    function automatic bit pause_now(bit side_on);
        if (!side_on)
            return 1'b0;
        return $urandom_range(99) < (idle_mode == 3 ? 7 : 72);
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= 50)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    task automatic write_register(logic idx, logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_ENTRIES_IN_USE)
            entries_cfg = data[MOD_W-1:0];
        else
            unknown_cfg = data;
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_valid || lookup_answers.size() != 0);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                predict_table_op(req);
            if (!req_valid || req_ready)
            begin
                if (pending_items.size() != 0 && !pause_now(idle_mode == 1 || idle_mode == 3))
                begin
                    req <= pending_items.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        tt_rsp_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (lookup_answers.size() == 0)
                    report_mismatch($sformatf("result with no lookup pending: hit %0b value %0d",
                                              rsp.hit, rsp.value));
                else
                begin
                    want = lookup_answers.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch($sformatf("hit %0b, want %0b", rsp.hit, want.hit));
                    if (rsp.value !== want.value)
                        report_mismatch($sformatf("value %0d, want %0d", rsp.value, want.value));
                end
            end
            rsp_ready <= !pause_now(idle_mode == 2 || idle_mode == 3);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        tt_req_t it;
        tt_req_t old;
        logic [15:0] entries_plan;
        logic [15:0] unknown_plan;
        int r;
        int made;

        clear_table();

        // zeroed entry, depth check, each bound type, window edges, aliasing, ignored kind, clear
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd0, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd0, 8'd1, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_INSERT, '1, 8'd255, 16'h7FFF, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, '1, 8'd255, 16'h0, BOUND_EXACT,
                                          16'h8000, 16'h7FFF));
        pending_items.push_back(make_item(KIND_INSERT, 64'd1, 8'd10, 16'h8000, BOUND_UPPER,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd1, 8'd10, 16'h0, BOUND_EXACT,
                                          16'h8000, 16'h7FFF));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd1, 8'd11, 16'h0, BOUND_EXACT,
                                          16'h8000, 16'h7FFF));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd1, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_INSERT, 64'd2, 8'd5, 16'd100, BOUND_LOWER,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd2, 8'd5, 16'h0, BOUND_EXACT,
                                          16'h0, 16'd100));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd2, 8'd5, 16'h0, BOUND_EXACT,
                                          16'h0, 16'd101));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd2, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h7FFF, 16'h8000));
        pending_items.push_back(make_item(KIND_INSERT, 64'd3, 8'd0, 16'd5, BOUND_UNUSED,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd3, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h7FFF, 16'h8000));
        pending_items.push_back(make_item(KIND_INSERT, 64'd4101, 8'd7, 16'hFFFF, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd5, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd4101, 8'd7, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_INSERT, 64'd6, 8'd3, 16'd200, BOUND_UPPER,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd6, 8'd3, 16'h0, BOUND_EXACT,
                                          16'd199, 16'h0));
        pending_items.push_back(make_item(KIND_IGNORED, '1, 8'hFF, 16'hFFFF, BOUND_UNUSED,
                                          16'hFFFF, 16'hFFFF));
        pending_items.push_back(make_item(KIND_CLEAR, '1, 8'hFF, 16'hFFFF, BOUND_UNUSED,
                                          16'hFFFF, 16'hFFFF));
        pending_items.push_back(make_item(KIND_LOOKUP, '1, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd0, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));
        pending_items.push_back(make_item(KIND_LOOKUP, 64'd4101, 8'd0, 16'h0, BOUND_EXACT,
                                          16'h0, 16'h0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_until_drained();
            // a clear may still be sweeping with nothing left to answer
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (p)
                0: begin entries_plan = 16'd16; unknown_plan = 16'h7FFF; end
                1: begin entries_plan = 16'd1; unknown_plan = 16'h0000; end
                2: begin entries_plan = 16'h2000; unknown_plan = 16'($urandom()); end
                3: begin entries_plan = 16'hFFFF; unknown_plan = 16'h8000; end
                4: begin entries_plan = 16'd4096; unknown_plan = 16'($urandom()); end
                5: begin entries_plan = 16'd4095; unknown_plan = 16'h0001; end
                6: begin entries_plan = 16'd7; unknown_plan = 16'hFFFF; end
                default:
                begin
                    entries_plan = 16'($urandom_range(4096, 1));
                    unknown_plan = 16'($urandom());
                end
            endcase
            write_register(CFG_ENTRIES_IN_USE, entries_plan);
            write_register(CFG_UNKNOWN_VALUE, unknown_plan);
            @(posedge clk);
            cfg_we <= 1'b0;
            idle_mode = p % 4;

            made = 0;
            while (made < PHASE_ITEMS)
            begin
                it.kind = KIND_LOOKUP;
                case ($urandom_range(3))
                    0: it.position_key = 64'($urandom_range(63));
                    1: it.position_key = 64'({$urandom_range(15), 12'd0})
                                         | 64'($urandom_range(15));
                    default: it.position_key = {$urandom(), $urandom()};
                endcase
                it.search_depth = 8'($urandom_range(255));
                it.score = random_score();
                it.bound_type = ($urandom_range(19) == 0) ? BOUND_UNUSED
                                                         : 2'($urandom_range(2));
                it.alpha = random_score();
                it.beta = random_score();
                r = $urandom_range(99);
                if (r < 2)
                    it.kind = KIND_CLEAR;
                else if (r < 4)
                    it.kind = KIND_IGNORED;
                else if (r < 40)
                begin
                    it.kind = KIND_INSERT;
                    inserted_pool.push_back(it);
                    if (inserted_pool.size() > POOL_DEPTH)
                        inserted_pool.delete(0);
                end
                else if (r < 88 && inserted_pool.size() != 0)
                begin
                    // lookup of a recently inserted key, window around its score
                    old = inserted_pool[$urandom_range(inserted_pool.size() - 1)];
                    it.position_key = old.position_key;
                    if ($urandom_range(3) != 0)
                        it.search_depth = 8'($urandom_range(old.search_depth));
                    if ($urandom_range(3) != 0)
                    begin
                        it.alpha = near_score(old.score);
                        it.beta = near_score(old.score);
                    end
                end
                else if (r >= 96)
                begin
                    it.position_key = '0;
                    it.search_depth = '0;
                end
                if (it.kind != KIND_IGNORED)
                    made++;
                pending_items.push_back(it);
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tt_pkg.sv
rtl/tt_mod_unit.sv
rtl/tt_store.sv
rtl/transposition_table.sv
rtl/tt_checker.sv
tb/transposition_table_tb.sv
